### design/efc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the encoder frame checker
// holds the crc column table used to check the frame crc; no dependencies
package efc_pkg;

    localparam int COUNT_BITS = 32;

    localparam int FRAME_W    = 32;
    localparam int POS_W      = 18;
    localparam int POS_LSB    = 14;
    localparam int CRC_DATA_W = 24;
    localparam int STUCK_W    = 16;
    localparam int LINK_W     = 8;
    localparam int CFG_DATA_W = 16;
    localparam int TOTAL_W    = 32;
    localparam int ERR_BIT    = 9;
    localparam int WARN_BIT   = 8;

    // result packing, lowest bit first
    localparam int OUT_RAW_W  = POS_W + 5 + 2 * TOTAL_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [7:0]             CRC_POLY   = 8'h97;
    localparam logic [FRAME_W-1:0]     FRAME_ONES = '1;
    localparam logic [STUCK_W-1:0]     STUCK_MAX  = '1;
    localparam logic [LINK_W-1:0]      LINK_MAX   = '1;
    localparam logic [COUNT_BITS-1:0]  CNT_MAX    = '1;

    localparam logic [STUCK_W-1:0]     STUCK_LIMIT_RST = 16'd20000;
    localparam logic [LINK_W-1:0]      LINK_LIMIT_RST  = 8'd5;

    typedef enum logic {
        REG_STUCK_LIMIT = 1'b0,
        REG_LINK_LIMIT  = 1'b1
    } t_cfg_reg;

    typedef logic [CRC_DATA_W-1:0][7:0] t_crc_cols;

    // crc of a word with a single data bit set, msb first, init zero
    function automatic t_crc_cols crc_col_table();
        t_crc_cols  cols;
        logic [7:0] crc;
        logic       fb;
        for (int b = 0; b < CRC_DATA_W; b++) begin
            crc = '0;
            for (int i = CRC_DATA_W - 1; i >= 0; i--) begin
                fb  = crc[7] ^ (i == b);
                crc = {crc[6:0], 1'b0};
                if (fb) begin
                    crc = crc ^ CRC_POLY;
                end
            end
            cols[b] = crc;
        end
        return cols;
    endfunction

    localparam t_crc_cols CRC_COLS = crc_col_table();

    // crc is linear with zero init, so xor the columns of the set bits
    function automatic logic [7:0] crc8_inv(input logic [CRC_DATA_W-1:0] data);
        logic [7:0] crc;
        crc = '0;
        for (int b = 0; b < CRC_DATA_W; b++) begin
            if (data[b]) begin
                crc = crc ^ CRC_COLS[b];
            end
        end
        return ~crc;
    endfunction

endpackage

### design/encoder_frame_checker.sv
`timescale 1ns / 1ps
// encoder frame checker top level: crc, flag, position and link checks per frame
// depends on efc_pkg for the crc table, widths and register codes
//
// usage:
//   s side takes one 32-bit raw encoder frame per request in s_tdata.
//   m side gives one result per frame: held position, update/crc/flag bits,
//   connection state and the two saturating failure totals.
//   cfg channel writes stuck_frame_limit (index 0) or link_error_limit (index 1);
//   it is always ready and should be used only while no frame is in flight.
// timing:
//   a frame accepted at one edge has its result on m side after that edge;
//   all checks and state updates are done in the single combinational path
//   from s_tdata to the result register.
//   one frame per cycle sustained; s_tready stays high while the result
//   register is empty or being taken in the same cycle.
// reset:
//   synchronous active low; clears all link, flag, position and count state,
//   empties the result register and loads limits 20000 and 5.
// stall:
//   when m_tready is low with a result waiting, s_tready drops and the
//   result holds until taken.
module encoder_frame_checker
    import efc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [FRAME_W-1:0]    i_s_tdata,   // [31:0] frame_word
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [17:0] position, [18] position_updated, [19] crc_ok, [20] error_raised,
    // [21] warning_raised, [22] link_connected, [54:23] crc_error_total,
    // [86:55] encoder_error_total, [87] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [STUCK_W-1:0]    r_stuck_limit;
    logic [LINK_W-1:0]     r_link_limit;
    logic [STUCK_W-1:0]    r_stuck_count, n_stuck_count;
    logic [LINK_W-1:0]     r_link_count, n_link_count;
    logic                  r_connected, n_connected;
    logic [POS_W-1:0]      r_position, n_position;
    logic                  r_err_held, n_err_held;
    logic                  r_warn_held, n_warn_held;
    logic [COUNT_BITS-1:0] r_crc_fails, n_crc_fails;
    logic [COUNT_BITS-1:0] r_enc_fails, n_enc_fails;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                  in_accept;
    logic                  stuck_frame;
    logic                  crc_good;
    logic                  updated;
    logic [STUCK_W-1:0]    stuck_step;
    logic [LINK_W-1:0]     link_good;
    logic                  conn_good;
    logic [LINK_W-1:0]     link_bad_inc;
    logic                  bad_step;

    assign in_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

    assign stuck_frame = (i_s_tdata == '0) || (i_s_tdata == FRAME_ONES);
    assign crc_good    = crc8_inv(i_s_tdata[FRAME_W-1:8]) == i_s_tdata[7:0];

    // link debounce: a good step first, then a bad step once the stuck run hits the limit
    always_comb begin
        if (stuck_frame) begin
            stuck_step = (r_stuck_count == STUCK_MAX) ? r_stuck_count
                                                      : r_stuck_count + 1'b1;
            link_good  = r_link_count;
            conn_good  = r_connected;
        end else begin
            stuck_step = '0;
            link_good  = (r_link_count != '0) ? r_link_count - 1'b1 : r_link_count;
            conn_good  = (r_link_count == '0) ? 1'b1 : r_connected;
        end

        bad_step      = stuck_step >= r_stuck_limit;
        link_bad_inc  = (link_good == LINK_MAX) ? link_good : link_good + 1'b1;
        n_stuck_count = bad_step ? r_stuck_limit : stuck_step;
        n_link_count  = link_good;
        n_connected   = conn_good;
        if (bad_step) begin
            if (link_bad_inc >= r_link_limit) begin
                n_link_count = r_link_limit;
                n_connected  = 1'b0;
            end else begin
                n_link_count = link_bad_inc;
            end
        end
    end

    // crc, flags, position and failure counts
    always_comb begin
        n_err_held  = r_err_held;
        n_warn_held = r_warn_held;
        n_position  = r_position;
        n_crc_fails = r_crc_fails;
        n_enc_fails = r_enc_fails;
        updated     = 1'b0;
        if (crc_good) begin
            n_err_held  = !i_s_tdata[ERR_BIT];
            n_warn_held = !i_s_tdata[WARN_BIT];
            if (i_s_tdata[ERR_BIT]) begin
                n_position = i_s_tdata[FRAME_W-1:POS_LSB];
                updated    = 1'b1;
            end else if (r_enc_fails != CNT_MAX) begin
                n_enc_fails = r_enc_fails + 1'b1;
            end
        end else if (r_crc_fails != CNT_MAX) begin
            n_crc_fails = r_crc_fails + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stuck_limit <= STUCK_LIMIT_RST;
            r_link_limit  <= LINK_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_STUCK_LIMIT: r_stuck_limit <= i_cfg_data;
                REG_LINK_LIMIT:  r_link_limit  <= i_cfg_data[LINK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stuck_count <= '0;
            r_link_count  <= '0;
            r_connected   <= 1'b0;
            r_position    <= '0;
            r_err_held    <= 1'b0;
            r_warn_held   <= 1'b0;
            r_crc_fails   <= '0;
            r_enc_fails   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_stuck_count <= n_stuck_count;
                r_link_count  <= n_link_count;
                r_connected   <= n_connected;
                r_position    <= n_position;
                r_err_held    <= n_err_held;
                r_warn_held   <= n_warn_held;
                r_crc_fails   <= n_crc_fails;
                r_enc_fails   <= n_enc_fails;
                r_out_valid   <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= OUT_DATA_W'({TOTAL_W'(n_enc_fails), TOTAL_W'(n_crc_fails),
                                      n_connected, n_warn_held, n_err_held,
                                      crc_good, updated, n_position});
        end
    end

    // every accepted frame leaves a result waiting
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_m_tvalid)
        else $error("no result after accepted frame");

    // a position update needs a good crc and no encoder error
    a_update_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[POS_W] |-> o_m_tdata[POS_W+1] && !o_m_tdata[POS_W+2])
        else $error("position updated from a rejected frame");

    // link error count never exceeds the configured ceiling after a bad step
    a_link_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && bad_step |=> r_link_count <= $past(r_link_limit))
        else $error("link error count above limit");

endmodule
